// ===== rtl/cbsm_pkg.sv =====
package cbsm_pkg;

  localparam int CB_WINDOW_MAX = 32;
  localparam int QUEUE_DEPTH   = 2;

  localparam int CMD_W  = 3;
  localparam int MODE_W = 2;
  localparam int OP_W   = 3;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int REG_W  = 3;
  localparam int LEN_W  = 6;
  localparam int THR_W  = 15;

  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REQUEST = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUCCESS = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FAILURE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FORCE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

  localparam logic [MODE_W-1:0] MODE_CLOSED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OPEN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HALF   = 2'd2;

  localparam logic [OP_W-1:0] OP_NOP   = 3'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 3'd1;
  localparam logic [OP_W-1:0] OP_REQ   = 3'd2;
  localparam logic [OP_W-1:0] OP_SUCC  = 3'd3;
  localparam logic [OP_W-1:0] OP_FAIL  = 3'd4;
  localparam logic [OP_W-1:0] OP_FORCE = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd6;

  localparam logic [REG_W-1:0] REG_FAIL_LIMIT    = 3'd0;
  localparam logic [REG_W-1:0] REG_SUCCESS_LIMIT = 3'd1;
  localparam logic [REG_W-1:0] REG_RECOVERY_MS   = 3'd2;
  localparam logic [REG_W-1:0] REG_RATE_LIMIT    = 3'd3;
  localparam logic [REG_W-1:0] REG_WINDOW_LEN    = 3'd4;

  localparam logic [7:0]       RST_FAIL_LIMIT    = 8'd5;
  localparam logic [7:0]       RST_SUCCESS_LIMIT = 8'd3;
  localparam logic [15:0]      RST_RECOVERY_MS   = 16'd30000;
  localparam logic [8:0]       RST_RATE_LIMIT    = 9'd128;
  localparam logic [LEN_W-1:0] RST_WINDOW_LEN    = 6'd20;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [MODE_W-1:0] forced_state;
  } cbsm_in_t;

  typedef struct packed {
    logic              allowed;
    logic [MODE_W-1:0] breaker_mode;
    logic [7:0]        fail_run;
    logic [5:0]        window_fails;
    logic [31:0]       fail_total;
    logic [31:0]       success_total;
  } cbsm_out_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [MODE_W-1:0] target;
  } cbsm_op_t;

  typedef struct packed {
    logic [7:0]       fail_limit;
    logic [7:0]       success_limit;
    logic [15:0]      recovery_ms;
    logic [LEN_W-1:0] eff_len;
    logic [THR_W-1:0] rate_thr;
  } cbsm_cfg_t;

endpackage

// ===== rtl/cbsm_cfg.sv =====
module cbsm_cfg #(
  parameter int WINDOW_MAX = cbsm_pkg::CB_WINDOW_MAX
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cbsm_pkg::ADDR_W-1:0] paddr,
  input  logic [cbsm_pkg::DATA_W-1:0] pwdata,
  output logic [cbsm_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output cbsm_pkg::cbsm_cfg_t         cfg
);

  logic [7:0]                 fail_limit_r;
  logic [7:0]                 success_limit_r;
  logic [15:0]                recovery_ms_r;
  logic [8:0]                 rate_limit_r;
  logic [8:0]                 rate_limit_nxt;
  logic [cbsm_pkg::LEN_W-1:0] window_len_r;
  logic [cbsm_pkg::LEN_W-1:0] window_len_nxt;
  logic [cbsm_pkg::LEN_W-1:0] eff_len_r;
  logic [cbsm_pkg::LEN_W-1:0] eff_len_nxt;
  logic [cbsm_pkg::THR_W-1:0] rate_thr_r;
  logic [cbsm_pkg::REG_W-1:0] reg_idx;
  logic                       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[cbsm_pkg::ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    rate_limit_nxt = rate_limit_r;
    window_len_nxt = window_len_r;
    if (wr_en && reg_idx == cbsm_pkg::REG_RATE_LIMIT) begin
      rate_limit_nxt = pwdata[8:0];
    end
    if (wr_en && reg_idx == cbsm_pkg::REG_WINDOW_LEN) begin
      window_len_nxt = pwdata[cbsm_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    if (window_len_nxt == '0) begin
      eff_len_nxt = cbsm_pkg::LEN_W'(1);
    end else if ({1'b0, window_len_nxt} > (cbsm_pkg::LEN_W+1)'(WINDOW_MAX)) begin
      eff_len_nxt = cbsm_pkg::LEN_W'(WINDOW_MAX);
    end else begin
      eff_len_nxt = window_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_limit_r    <= cbsm_pkg::RST_FAIL_LIMIT;
      success_limit_r <= cbsm_pkg::RST_SUCCESS_LIMIT;
      recovery_ms_r   <= cbsm_pkg::RST_RECOVERY_MS;
      rate_limit_r    <= cbsm_pkg::RST_RATE_LIMIT;
      window_len_r    <= cbsm_pkg::RST_WINDOW_LEN;
    end else if (wr_en) begin
      unique case (reg_idx)
        cbsm_pkg::REG_FAIL_LIMIT:    fail_limit_r    <= pwdata[7:0];
        cbsm_pkg::REG_SUCCESS_LIMIT: success_limit_r <= pwdata[7:0];
        cbsm_pkg::REG_RECOVERY_MS:   recovery_ms_r   <= pwdata[15:0];
        cbsm_pkg::REG_RATE_LIMIT:    rate_limit_r    <= pwdata[8:0];
        cbsm_pkg::REG_WINDOW_LEN:    window_len_r    <= pwdata[cbsm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // full-window rate threshold: rate_limit * window length
  always_ff @(posedge clk) begin
    eff_len_r  <= eff_len_nxt;
    rate_thr_r <= cbsm_pkg::THR_W'(rate_limit_nxt) * cbsm_pkg::THR_W'(eff_len_nxt);
  end

  always_comb begin
    unique case (reg_idx)
      cbsm_pkg::REG_FAIL_LIMIT:    prdata = cbsm_pkg::DATA_W'(fail_limit_r);
      cbsm_pkg::REG_SUCCESS_LIMIT: prdata = cbsm_pkg::DATA_W'(success_limit_r);
      cbsm_pkg::REG_RECOVERY_MS:   prdata = cbsm_pkg::DATA_W'(recovery_ms_r);
      cbsm_pkg::REG_RATE_LIMIT:    prdata = cbsm_pkg::DATA_W'(rate_limit_r);
      cbsm_pkg::REG_WINDOW_LEN:    prdata = cbsm_pkg::DATA_W'(window_len_r);
      default:                     prdata = '0;
    endcase
  end

  assign cfg.fail_limit    = fail_limit_r;
  assign cfg.success_limit = success_limit_r;
  assign cfg.recovery_ms   = recovery_ms_r;
  assign cfg.eff_len       = eff_len_r;
  assign cfg.rate_thr      = rate_thr_r;

endmodule

// ===== rtl/cbsm_front.sv =====
module cbsm_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  cbsm_pkg::cbsm_in_t in_data,
  input  logic               q_full,
  output logic               q_push,
  output cbsm_pkg::cbsm_op_t q_wdata
);

  assign in_ready = ~q_full;
  assign q_push   = in_valid & in_ready;

  always_comb begin
    q_wdata.target = in_data.forced_state;
    unique case (in_data.cmd)
      cbsm_pkg::CMD_TICK:    q_wdata.op = cbsm_pkg::OP_TICK;
      cbsm_pkg::CMD_REQUEST: q_wdata.op = cbsm_pkg::OP_REQ;
      cbsm_pkg::CMD_SUCCESS: q_wdata.op = cbsm_pkg::OP_SUCC;
      cbsm_pkg::CMD_FAILURE: q_wdata.op = cbsm_pkg::OP_FAIL;
      cbsm_pkg::CMD_FORCE: begin
        // drop a force to an undefined mode
        if (in_data.forced_state == cbsm_pkg::MODE_CLOSED ||
            in_data.forced_state == cbsm_pkg::MODE_OPEN ||
            in_data.forced_state == cbsm_pkg::MODE_HALF) begin
          q_wdata.op = cbsm_pkg::OP_FORCE;
        end else begin
          q_wdata.op = cbsm_pkg::OP_NOP;
        end
      end
      cbsm_pkg::CMD_CLEAR:   q_wdata.op = cbsm_pkg::OP_CLEAR;
      default:               q_wdata.op = cbsm_pkg::OP_NOP;
    endcase
  end

endmodule

// ===== rtl/cbsm_queue.sv =====
module cbsm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cbsm_pkg::cbsm_op_t wdata,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output cbsm_pkg::cbsm_op_t rdata
);

  localparam int DEPTH = cbsm_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cbsm_pkg::cbsm_op_t entry_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign rdata     = entry_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/cbsm_back.sv =====
module cbsm_back #(
  parameter int WINDOW_MAX = cbsm_pkg::CB_WINDOW_MAX
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cbsm_pkg::cbsm_cfg_t cfg,
  input  logic                q_not_empty,
  input  cbsm_pkg::cbsm_op_t  q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output cbsm_pkg::cbsm_out_t out_data
);

  localparam int LW = cbsm_pkg::LEN_W;
  localparam int MW = cbsm_pkg::MODE_W;

  logic [MW-1:0]         mode_r, mode_nxt;
  logic [7:0]            fail_streak_r, fail_streak_nxt;
  logic [7:0]            succ_streak_r, succ_streak_nxt;
  logic [31:0]           fail_tot_r, fail_tot_nxt;
  logic [31:0]           succ_tot_r, succ_tot_nxt;
  logic [15:0]           since_r, since_nxt;
  logic [WINDOW_MAX-1:0] hist_r, hist_nxt;
  logic [LW-1:0]         fill_r, fill_nxt;
  logic [LW-1:0]         wcnt_r, wcnt_nxt;
  logic                  out_valid_r;
  cbsm_pkg::cbsm_out_t   out_r, out_nxt;

  logic                  allowed;
  logic                  chg;
  logic [MW-1:0]         chg_mode;
  logic [LW-1:0]         fill_push;
  logic [WINDOW_MAX-1:0] hist_mask;
  logic [WINDOW_MAX-1:0] hist_push;
  logic [LW-1:0]         wcnt_push;
  logic [7:0]            fs_inc;
  logic [7:0]            ss_inc;
  logic                  rate_trip;

  assign q_pop     = q_not_empty & (~out_valid_r | out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // outcome window after pushing one outcome
  always_comb begin
    fill_push = (fill_r >= cfg.eff_len) ? cfg.eff_len : fill_r + LW'(1);
    for (int i = 0; i < WINDOW_MAX; i++) begin
      hist_mask[i] = (32'(i) < 32'(fill_push));
    end
    hist_push = {hist_r[WINDOW_MAX-2:0], (q_rdata.op == cbsm_pkg::OP_FAIL)} & hist_mask;
    wcnt_push = LW'($countones(hist_push));
  end

  assign fs_inc    = (fail_streak_r == 8'hFF) ? fail_streak_r : fail_streak_r + 8'd1;
  assign ss_inc    = (succ_streak_r == 8'hFF) ? succ_streak_r : succ_streak_r + 8'd1;
  assign rate_trip = (fill_push >= cfg.eff_len) &&
                     ({1'b0, wcnt_push, 8'd0} >= cfg.rate_thr);

  always_comb begin
    mode_nxt        = mode_r;
    fail_streak_nxt = fail_streak_r;
    succ_streak_nxt = succ_streak_r;
    fail_tot_nxt    = fail_tot_r;
    succ_tot_nxt    = succ_tot_r;
    since_nxt       = since_r;
    hist_nxt        = hist_r;
    fill_nxt        = fill_r;
    wcnt_nxt        = wcnt_r;
    allowed         = 1'b0;
    chg             = 1'b0;
    chg_mode        = mode_r;

    unique case (q_rdata.op)
      cbsm_pkg::OP_TICK: begin
        if (since_r != 16'hFFFF) begin
          since_nxt = since_r + 16'd1;
        end
      end
      cbsm_pkg::OP_REQ: begin
        if (mode_r == cbsm_pkg::MODE_OPEN) begin
          if (since_r >= cfg.recovery_ms) begin
            chg      = 1'b1;
            chg_mode = cbsm_pkg::MODE_HALF;
            allowed  = 1'b1;
          end
        end else begin
          allowed = 1'b1;
        end
      end
      cbsm_pkg::OP_SUCC: begin
        if (succ_tot_r != 32'hFFFF_FFFF) begin
          succ_tot_nxt = succ_tot_r + 32'd1;
        end
        hist_nxt = hist_push;
        fill_nxt = fill_push;
        wcnt_nxt = wcnt_push;
        if (mode_r == cbsm_pkg::MODE_HALF) begin
          succ_streak_nxt = ss_inc;
          if (ss_inc >= cfg.success_limit) begin
            chg      = 1'b1;
            chg_mode = cbsm_pkg::MODE_CLOSED;
          end
        end else if (mode_r == cbsm_pkg::MODE_CLOSED) begin
          fail_streak_nxt = '0;
        end
      end
      cbsm_pkg::OP_FAIL: begin
        if (fail_tot_r != 32'hFFFF_FFFF) begin
          fail_tot_nxt = fail_tot_r + 32'd1;
        end
        since_nxt = '0;
        hist_nxt  = hist_push;
        fill_nxt  = fill_push;
        wcnt_nxt  = wcnt_push;
        if (mode_r == cbsm_pkg::MODE_CLOSED) begin
          fail_streak_nxt = fs_inc;
          if (fs_inc >= cfg.fail_limit || rate_trip) begin
            chg      = 1'b1;
            chg_mode = cbsm_pkg::MODE_OPEN;
          end
        end else if (mode_r == cbsm_pkg::MODE_HALF) begin
          succ_streak_nxt = '0;
          chg             = 1'b1;
          chg_mode        = cbsm_pkg::MODE_OPEN;
        end
      end
      cbsm_pkg::OP_FORCE: begin
        chg      = 1'b1;
        chg_mode = q_rdata.target;
      end
      cbsm_pkg::OP_CLEAR: begin
        mode_nxt        = cbsm_pkg::MODE_CLOSED;
        fail_streak_nxt = '0;
        succ_streak_nxt = '0;
        fail_tot_nxt    = '0;
        succ_tot_nxt    = '0;
        hist_nxt        = '0;
        fill_nxt        = '0;
        wcnt_nxt        = '0;
      end
      default: ;
    endcase

    if (chg && chg_mode != mode_r) begin
      mode_nxt        = chg_mode;
      succ_streak_nxt = '0;
      if (chg_mode == cbsm_pkg::MODE_CLOSED) begin
        fail_streak_nxt = '0;
      end
    end

    out_nxt.allowed       = allowed;
    out_nxt.breaker_mode  = mode_nxt;
    out_nxt.fail_run      = fail_streak_nxt;
    out_nxt.window_fails  = wcnt_nxt;
    out_nxt.fail_total    = fail_tot_nxt;
    out_nxt.success_total = succ_tot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= cbsm_pkg::MODE_CLOSED;
      fail_streak_r <= '0;
      succ_streak_r <= '0;
      fail_tot_r    <= '0;
      succ_tot_r    <= '0;
      since_r       <= 16'hFFFF;
      hist_r        <= '0;
      fill_r        <= '0;
      wcnt_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (q_pop) begin
        mode_r        <= mode_nxt;
        fail_streak_r <= fail_streak_nxt;
        succ_streak_r <= succ_streak_nxt;
        fail_tot_r    <= fail_tot_nxt;
        succ_tot_r    <= succ_tot_nxt;
        since_r       <= since_nxt;
        hist_r        <= hist_nxt;
        fill_r        <= fill_nxt;
        wcnt_r        <= wcnt_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== rtl/circuit_breaker_state_machine_core.sv =====
// Channel  Handshake            Payload                Direction
// in_      in_valid/in_ready    in_data  (cbsm_in_t)   input requests
// out_     out_valid/out_ready  out_data (cbsm_out_t)  one result per request
// cfg      psel/penable/pwrite  paddr, pwdata, prdata  APB register access
//
// One request per cycle sustained while out_ready is high; a request is registered in
// the queue and then in the output register. The front classifies into a two-entry
// queue; the back updates state and the output register together on each pop.
// The back stalls only on out_ready; the front stalls only on a full queue.
// Reset (synchronous, rst_n low) loads register defaults, clears streaks and totals.
module circuit_breaker_state_machine_core #(
  parameter int WINDOW_MAX = cbsm_pkg::CB_WINDOW_MAX
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cbsm_pkg::cbsm_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cbsm_pkg::cbsm_out_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cbsm_pkg::ADDR_W-1:0] paddr,
  input  logic [cbsm_pkg::DATA_W-1:0] pwdata,
  output logic [cbsm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  cbsm_pkg::cbsm_cfg_t cfg;
  cbsm_pkg::cbsm_op_t  q_wdata;
  cbsm_pkg::cbsm_op_t  q_rdata;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_not_empty;

  cbsm_cfg #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  cbsm_front u_front (
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  cbsm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .rdata    (q_rdata)
  );

  cbsm_back #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_not_empty(q_not_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== rtl/cbsm_checker.sv =====
module cbsm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input cbsm_pkg::cbsm_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_allowed_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.allowed |-> out_data.breaker_mode != cbsm_pkg::MODE_OPEN)
    else $error("request allowed while breaker open");

  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.window_fails) <= out_data.fail_total &&
                  32'(out_data.fail_run) <= out_data.fail_total)
    else $error("failure counts inconsistent");

endmodule

bind circuit_breaker_state_machine_core cbsm_checker u_chk (.*);

// ===== verif/circuit_breaker_state_machine_core_tb.sv =====
module circuit_breaker_state_machine_core_tb;
  import cbsm_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 70;
  localparam int LONG_HOLD = 120;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam logic [MODE_W-1:0] MODE_BAD = 2'd3;

  class breaker_scoreboard;
    logic [7:0]  fail_limit;
    logic [7:0]  success_limit;
    logic [15:0] recovery_ms;
    logic [8:0]  rate_limit;
    logic [5:0]  window_len;

    logic [MODE_W-1:0]        mode;
    logic [7:0]               fail_streak;
    logic [7:0]               success_streak;
    logic [31:0]              fail_tot;
    logic [31:0]              succ_tot;
    logic [15:0]              since_fail;
    logic [CB_WINDOW_MAX-1:0] history;
    int unsigned              fill;
    int unsigned              window_fail_cnt;

    cbsm_out_t expected_q[$];
    int errors;
    int checked;
    int noted;
    int opens;
    int half_entries;
    int half_closes;

    function new();
      fail_limit = RST_FAIL_LIMIT;
      success_limit = RST_SUCCESS_LIMIT;
      recovery_ms = RST_RECOVERY_MS;
      rate_limit = RST_RATE_LIMIT;
      window_len = RST_WINDOW_LEN;
      mode = MODE_CLOSED;
      fail_streak = '0;
      success_streak = '0;
      fail_tot = '0;
      succ_tot = '0;
      since_fail = 16'hFFFF;
      history = '0;
      fill = 0;
      window_fail_cnt = 0;
      errors = 0;
      checked = 0;
      noted = 0;
      opens = 0;
      half_entries = 0;
      half_closes = 0;
    endfunction

    function void set_reg(logic [REG_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_FAIL_LIMIT: fail_limit = val[7:0];
        REG_SUCCESS_LIMIT: success_limit = val[7:0];
        REG_RECOVERY_MS: recovery_ms = val[15:0];
        REG_RATE_LIMIT: rate_limit = val[8:0];
        REG_WINDOW_LEN: window_len = val[5:0];
        default: ;
      endcase
    endfunction

    function int unsigned window_span();
      if (window_len == 0) return 1;
      if (window_len > CB_WINDOW_MAX) return CB_WINDOW_MAX;
      return window_len;
    endfunction

    function void record_outcome(bit failed);
      int unsigned span;
      span = window_span();
      history = {history[CB_WINDOW_MAX-2:0], failed};
      if (fill < 64) fill++;
      if (fill > span) fill = span;
      if (fill < CB_WINDOW_MAX) history &= (({{(CB_WINDOW_MAX-1){1'b0}}, 1'b1} << fill) - 1);
      window_fail_cnt = $countones(history);
    endfunction

    function void enter_mode(logic [MODE_W-1:0] m);
      if (m == mode) return;
      if (m == MODE_OPEN) opens++;
      if (m == MODE_HALF) half_entries++;
      if (m == MODE_CLOSED && mode == MODE_HALF) half_closes++;
      mode = m;
      success_streak = '0;
      if (m == MODE_CLOSED) fail_streak = '0;
    endfunction

    function void note_request(cbsm_in_t r);
      cbsm_out_t e;
      logic allow;
      allow = 1'b0;
      case (r.cmd)
        CMD_TICK: if (since_fail != 16'hFFFF) since_fail++;
        CMD_REQUEST: begin
          if (mode == MODE_OPEN) begin
            if (since_fail >= recovery_ms) begin
              enter_mode(MODE_HALF);
              allow = 1'b1;
            end
          end else begin
            allow = 1'b1;
          end
        end
        CMD_SUCCESS: begin
          if (succ_tot != 32'hFFFF_FFFF) succ_tot++;
          record_outcome(1'b0);
          if (mode == MODE_HALF) begin
            if (success_streak != 8'hFF) success_streak++;
            if (success_streak >= success_limit) enter_mode(MODE_CLOSED);
          end else if (mode == MODE_CLOSED) begin
            fail_streak = '0;
          end
        end
        CMD_FAILURE: begin
          if (fail_tot != 32'hFFFF_FFFF) fail_tot++;
          since_fail = '0;
          record_outcome(1'b1);
          if (mode == MODE_CLOSED) begin
            if (fail_streak != 8'hFF) fail_streak++;
            if (fail_streak >= fail_limit) begin
              enter_mode(MODE_OPEN);
            end else if (fill >= window_span()) begin
              if (window_fail_cnt * 256 >= rate_limit * fill) enter_mode(MODE_OPEN);
            end
          end else if (mode == MODE_HALF) begin
            enter_mode(MODE_OPEN);
          end
        end
        CMD_FORCE: if (r.forced_state <= MODE_HALF) enter_mode(r.forced_state);
        CMD_CLEAR: begin
          mode = MODE_CLOSED;
          fail_streak = '0;
          success_streak = '0;
          fail_tot = '0;
          succ_tot = '0;
          history = '0;
          fill = 0;
          window_fail_cnt = 0;
        end
        default: ;
      endcase
      e.allowed = allow;
      e.breaker_mode = mode;
      e.fail_run = fail_streak;
      e.window_fails = window_fail_cnt[5:0];
      e.fail_total = fail_tot;
      e.success_total = succ_tot;
      expected_q.insert(expected_q.size(), e);
      noted++;
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch at result %0d: %s", checked, msg);
      errors++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task check_result(cbsm_out_t got);
      cbsm_out_t e;
      if (expected_q.size() == 0) begin
        report("result with no request pending");
        return;
      end
      e = expected_q[0];
      expected_q.delete(0);
      check_field("allowed", 32'(got.allowed), 32'(e.allowed));
      check_field("breaker_mode", 32'(got.breaker_mode), 32'(e.breaker_mode));
      check_field("fail_run", 32'(got.fail_run), 32'(e.fail_run));
      check_field("window_fails", 32'(got.window_fails), 32'(e.window_fails));
      check_field("fail_total", got.fail_total, e.fail_total);
      check_field("success_total", got.success_total, e.success_total);
      checked++;
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  cbsm_in_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  cbsm_out_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  breaker_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int settings = 0;

  circuit_breaker_state_machine_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("circuit_breaker_state_machine_core_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !long_hold_done) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic cbsm_in_t make_request(logic [CMD_W-1:0] c, logic [MODE_W-1:0] f);
    cbsm_in_t r;
    r.cmd = c;
    r.forced_state = f;
    return r;
  endfunction

  function automatic cbsm_in_t random_request();
    cbsm_in_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    r.forced_state = MODE_W'($urandom_range(2));
    if (pick < 25) r.cmd = CMD_TICK;
    else if (pick < 45) r.cmd = CMD_REQUEST;
    else if (pick < 68) r.cmd = CMD_SUCCESS;
    else if (pick < 88) r.cmd = CMD_FAILURE;
    else if (pick < 95) begin
      r.cmd = CMD_FORCE;
      if ($urandom_range(9) == 0) r.forced_state = MODE_BAD;
    end else if (pick < 98) r.cmd = CMD_CLEAR;
    else begin
      r.cmd = CMD_W'($urandom_range(7));
      r.forced_state = MODE_W'($urandom_range(3));
    end
    return r;
  endfunction

  task automatic offer(input cbsm_in_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic load_settings(input int p);
    logic [31:0] fl, sl, rm, rl, wl;
    case (p)
      0: begin fl = 1; sl = 1; rm = 0; rl = 0; wl = 1; end
      1: begin fl = 255; sl = 255; rm = 65535; rl = 511; wl = 63; end
      2: begin fl = 3; sl = 2; rm = 4; rl = 128; wl = 8; end
      3: begin fl = 0; sl = 0; rm = 2; rl = 256; wl = 32; end
      default: begin
        fl = $urandom_range(6, 1);
        sl = $urandom_range(4);
        rm = $urandom_range(12);
        rl = $urandom_range(300);
        wl = $urandom_range(40);
      end
    endcase
    write_reg(REG_FAIL_LIMIT, fl);
    write_reg(REG_SUCCESS_LIMIT, sl);
    write_reg(REG_RECOVERY_MS, rm);
    write_reg(REG_RATE_LIMIT, rl);
    write_reg(REG_WINDOW_LEN, wl);
    settings++;
  endtask

  initial begin
    cbsm_in_t burst_req;
    int burst_len;
    int phase_items;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 22;
    rx_idle_pct <= 57;
    @(posedge clk);

    offer(make_request(CMD_TICK, MODE_CLOSED));
    offer(make_request(CMD_SPARE_HI, MODE_BAD));
    offer(make_request(CMD_REQUEST, MODE_CLOSED));
    offer(make_request(CMD_SUCCESS, MODE_CLOSED));
    repeat (5) offer(make_request(CMD_FAILURE, MODE_CLOSED));
    offer(make_request(CMD_REQUEST, MODE_CLOSED));
    offer(make_request(CMD_TICK, MODE_CLOSED));
    offer(make_request(CMD_SUCCESS, MODE_CLOSED));
    offer(make_request(CMD_FAILURE, MODE_CLOSED));
    offer(make_request(CMD_FORCE, MODE_BAD));
    offer(make_request(CMD_FORCE, MODE_OPEN));
    offer(make_request(CMD_FORCE, MODE_HALF));
    offer(make_request(CMD_SUCCESS, MODE_CLOSED));
    offer(make_request(CMD_FAILURE, MODE_CLOSED));
    offer(make_request(CMD_FORCE, MODE_HALF));
    repeat (3) offer(make_request(CMD_SUCCESS, MODE_CLOSED));
    offer(make_request(CMD_FORCE, MODE_CLOSED));
    offer(make_request(CMD_SPARE_LO, MODE_CLOSED));
    offer(make_request(CMD_CLEAR, MODE_CLOSED));
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin tx_idle_pct = 22; rx_idle_pct <= 57; end
        1: begin tx_idle_pct = 57; rx_idle_pct <= 22; end
        default: begin tx_idle_pct = 0; rx_idle_pct <= 0; end
      endcase
      load_settings(p);
      if (p == 4) long_hold_req <= 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(99) < 15) begin
          burst_req = random_request();
          case ($urandom_range(2))
            0: burst_req.cmd = CMD_TICK;
            1: burst_req.cmd = CMD_SUCCESS;
            default: burst_req.cmd = CMD_FAILURE;
          endcase
          burst_len = $urandom_range(6, 2);
          repeat (burst_len) begin
            offer(burst_req);
            phase_items++;
          end
        end else begin
          offer(random_request());
          phase_items++;
        end
      end
      drain();
    end

    $display("%0d requests sent, %0d results checked over %0d register settings",
             sb.noted, sb.checked, settings);
    $display("breaker opened %0d times, probed into half-open %0d times, recovered %0d times",
             sb.opens, sb.half_entries, sb.half_closes);
    if (sb.errors == 0) begin
      $display("circuit_breaker_state_machine_core_tb OK");
    end else begin
      $display("circuit_breaker_state_machine_core_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cbsm_pkg.sv
rtl/cbsm_cfg.sv
rtl/cbsm_front.sv
rtl/cbsm_queue.sv
rtl/cbsm_back.sv
rtl/circuit_breaker_state_machine_core.sv
rtl/cbsm_checker.sv
verif/circuit_breaker_state_machine_core_tb.sv
